@@ rtl/qs_pkg.sv @@
// qs_pkg: shared types and the signed compare used by the quicksort engine.
// No dependencies; imported by the top level.
`default_nettype none

package qs_pkg;

   // one stored element, two's complement
   typedef logic signed [31:0] value_type;

   // ascending order test used by the partition scan
   function automatic logic less_signed(input value_type a, input value_type b);
      return a < b;
   endfunction

endpackage : qs_pkg

`default_nettype wire

@@ rtl/quicksort_engine.sv @@
// quicksort_engine: batch sorter for signed 32-bit values.
// Depends on qs_pkg and qs_ram (element store and range stack).
//
// Values are loaded one item per cycle while busy is low; an item with
// req_last set closes the batch, and busy rises. Items past DEPTH are
// dropped and rsp_overflow is set on every result of that batch. The batch
// is then sorted in place by quicksort (last element as pivot) with an
// explicit range stack, one store access per cycle through a single
// compare unit: each partition pops a range, reads its pivot, scans the
// rest, moves smaller ones down, places the pivot and queues the sides.
// The sorted values then leave one per cycle on rsp_strobe, the final one
// flagged by rsp_final_res. The receiver cannot stall: every strobed
// result must be taken in its cycle. Already sorted input is the slow case.
`default_nettype none

module quicksort_engine #(
   parameter int DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire qs_pkg::value_type req_value,
   input  wire logic              req_last,
   output logic                   rsp_strobe,
   output qs_pkg::value_type      rsp_sorted_value,
   output logic                   rsp_final_res,
   output logic                   rsp_overflow
);

   import qs_pkg::*;

   localparam int IW  = $clog2(DEPTH);       // element index
   localparam int CW  = $clog2(DEPTH + 1);   // element count
   localparam int SD  = DEPTH;               // range stack entries
   localparam int SPW = $clog2(SD + 1);      // stack pointer
   localparam int SAW = $clog2(SD);          // stack address

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_POP   = 4'd2;
   localparam logic [3:0] S_POPW  = 4'd3;
   localparam logic [3:0] S_PIV   = 4'd4;
   localparam logic [3:0] S_ISSUE = 4'd5;
   localparam logic [3:0] S_SCAN  = 4'd6;
   localparam logic [3:0] S_SWAP1 = 4'd7;
   localparam logic [3:0] S_SWAP2 = 4'd8;
   localparam logic [3:0] S_FIN1  = 4'd9;
   localparam logic [3:0] S_FIN2  = 4'd10;
   localparam logic [3:0] S_PUSH1 = 4'd11;
   localparam logic [3:0] S_PUSH2 = 4'd12;
   localparam logic [3:0] S_EMIT  = 4'd13;

   logic [3:0]     state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [IW-1:0]  lo_ff, lo_in;
   logic [IW-1:0]  hi_ff, hi_in;
   logic [IW-1:0]  j_ff, j_in;
   logic [IW-1:0]  place_ff, place_in;
   logic [CW-1:0]  k_ff, k_in;
   value_type      pivot_ff, pivot_in;
   value_type      hold_ff, hold_in;
   logic [2*IW:0]  push_a_ff, push_a_in;   // {valid, lo, hi}
   logic [2*IW:0]  push_b_ff, push_b_in;
   logic           strobe_ff, strobe_in;
   logic           final_ff, final_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   // element store port
   logic           st_we, st_re;
   logic [IW-1:0]  st_waddr, st_raddr;
   value_type      st_wdata, st_rdata;

   // range stack port
   logic            sk_we, sk_re;
   logic [SAW-1:0]  sk_waddr, sk_raddr;
   logic [2*IW-1:0] sk_wdata, sk_rdata;

   // partition outcome
   logic          left_ok, right_ok, left_big;
   logic [2*IW:0] left_rng, right_rng;

   qs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   qs_ram #(.WIDTH(2 * IW), .DEPTH(SD)) u_stack (
      .clock   (clock),
      .wr_en   (sk_we),
      .wr_addr (sk_waddr),
      .wr_data (sk_wdata),
      .rd_en   (sk_re),
      .rd_addr (sk_raddr),
      .rd_data (sk_rdata)
   );

   // split the finished range around the pivot position
   always_comb begin
      left_ok   = {1'b0, place_ff} > ({1'b0, lo_ff} + 1'b1);
      right_ok  = ({1'b0, place_ff} + 1'b1) < {1'b0, hi_ff};
      left_big  = (place_ff - lo_ff) > (hi_ff - place_ff);
      left_rng  = {left_ok, lo_ff, place_ff - 1'b1};
      right_rng = {right_ok, place_ff + 1'b1, hi_ff};
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      sp_in      = sp_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      j_in       = j_ff;
      place_in   = place_ff;
      k_in       = k_ff;
      pivot_in   = pivot_ff;
      hold_in    = hold_ff;
      push_a_in  = push_a_ff;
      push_b_in  = push_b_ff;
      strobe_in  = 1'b0;
      final_in   = final_ff;
      rsp_ovf_in = rsp_ovf_ff;

      st_we    = 1'b0;
      st_waddr = place_ff;
      st_wdata = hold_ff;
      st_re    = 1'b0;
      st_raddr = j_ff;
      sk_we    = 1'b0;
      sk_waddr = sp_ff[SAW-1:0];
      sk_wdata = push_a_ff[2*IW-1:0];
      sk_re    = 1'b0;
      sk_raddr = sp_ff[SAW-1:0] - 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            // load one item, drop it when the store is full
            if (start) begin
               if (count_ff < CW'(DEPTH)) begin
                  st_we    = 1'b1;
                  st_waddr = count_ff[IW-1:0];
                  st_wdata = req_value;
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            // push the whole batch as the first range; a batch under two goes to emission
            k_in  = '0;
            sp_in = '0;
            if (count_ff < CW'(2)) begin
               state_in = S_EMIT;
            end else begin
               sk_we    = 1'b1;
               sk_waddr = '0;
               sk_wdata = {IW'(0), IW'(count_ff - 1'b1)};
               sp_in    = SPW'(1);
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               k_in     = '0;
               state_in = S_EMIT;
            end else begin
               sk_re    = 1'b1;
               sp_in    = sp_ff - 1'b1;
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            // open the range and fetch its pivot
            lo_in    = sk_rdata[2*IW-1:IW];
            hi_in    = sk_rdata[IW-1:0];
            j_in     = sk_rdata[2*IW-1:IW];
            place_in = sk_rdata[2*IW-1:IW];
            st_re    = 1'b1;
            st_raddr = sk_rdata[IW-1:0];
            state_in = S_PIV;
         end
         S_PIV: begin
            pivot_in = st_rdata;
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            // fetch the next scanned element, or the pivot's new home
            st_re = 1'b1;
            if (j_ff == hi_ff) begin
               st_raddr = place_ff;
               state_in = S_FIN1;
            end else begin
               st_raddr = j_ff;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (less_signed(st_rdata, pivot_ff)) begin
               hold_in  = st_rdata;
               st_re    = 1'b1;
               st_raddr = place_ff;
               state_in = S_SWAP1;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_ISSUE;
            end
         end
         S_SWAP1: begin
            // move the small element down, keep the displaced one
            st_we    = 1'b1;
            st_waddr = place_ff;
            st_wdata = hold_ff;
            hold_in  = st_rdata;
            state_in = S_SWAP2;
         end
         S_SWAP2: begin
            st_we    = 1'b1;
            st_waddr = j_ff;
            st_wdata = hold_ff;
            place_in = place_ff + 1'b1;
            j_in     = j_ff + 1'b1;
            state_in = S_ISSUE;
         end
         S_FIN1: begin
            st_we    = 1'b1;
            st_waddr = hi_ff;
            st_wdata = st_rdata;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            // drop the pivot in place, queue the two sides larger first
            st_we    = 1'b1;
            st_waddr = place_ff;
            st_wdata = pivot_ff;
            if (left_big) begin
               push_a_in = left_rng;
               push_b_in = right_rng;
            end else begin
               push_a_in = right_rng;
               push_b_in = left_rng;
            end
            state_in = S_PUSH1;
         end
         S_PUSH1: begin
            if (push_a_ff[2*IW] && sp_ff < SPW'(SD)) begin
               sk_we    = 1'b1;
               sk_wdata = push_a_ff[2*IW-1:0];
               sp_in    = sp_ff + 1'b1;
            end
            state_in = S_PUSH2;
         end
         S_PUSH2: begin
            if (push_b_ff[2*IW] && sp_ff < SPW'(SD)) begin
               sk_we    = 1'b1;
               sk_wdata = push_b_ff[2*IW-1:0];
               sp_in    = sp_ff + 1'b1;
            end
            state_in = S_POP;
         end
         S_EMIT: begin
            // read one sorted element a cycle, close the batch on the last
            st_re      = 1'b1;
            st_raddr   = k_ff[IW-1:0];
            strobe_in  = 1'b1;
            final_in   = (k_ff + 1'b1) == count_ff;
            rsp_ovf_in = ovf_ff;
            k_in       = k_ff + 1'b1;
            if ((k_ff + 1'b1) == count_ff) begin
               count_in = '0;
               ovf_in   = 1'b0;
               sp_in    = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         sp_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         sp_ff     <= sp_in;
         strobe_ff <= strobe_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      j_ff       <= j_in;
      place_ff   <= place_in;
      k_ff       <= k_in;
      pivot_ff   <= pivot_in;
      hold_ff    <= hold_in;
      push_a_ff  <= push_a_in;
      push_b_ff  <= push_b_in;
      final_ff   <= final_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign busy             = state_ff != S_IDLE;
   assign rsp_strobe       = strobe_ff;
   assign rsp_sorted_value = st_rdata;
   assign rsp_final_res    = final_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule : quicksort_engine

`default_nettype wire

@@ rtl/qs_ram.sv @@
// qs_ram: generic single-write, single-read memory with registered read data.
// No dependencies; used for the element store and the range stack.
`default_nettype none

module qs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : qs_ram

`default_nettype wire
